/* hw/rtl/olst_pkg.sv */
// Shared types and constants of the ordered unique id list.
// Used by olst_ctrl, ordered_unique_id_list_core, olst_props, olst_chk and tb.
// Depends on nothing.
package olst_pkg;

    localparam int DEPTH_DEFAULT   = 64;
    localparam int ID_BITS_DEFAULT = 16;

    // Fixed widths of the request and response fields.
    localparam int ID_FIELD_W    = 16;
    localparam int FUNC_W        = 3;
    localparam int STATUS_W      = 2;
    localparam int COUNT_FIELD_W = 7;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT = 3'd0,
        FN_REMOVE = 3'd1,
        FN_FIRST  = 3'd2,
        FN_NEXT   = 3'd3,
        FN_SIZE   = 3'd4
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_PRESENT = 2'd1,
        ST_MISSING = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_FETCH,
        S_FDATA,
        S_RESP
    } state_t;

    // Handshake between the sequencer and the response register.
    typedef struct packed {
        logic    done;
        status_t status;
    } resp_ctl_t;

endpackage

/* hw/rtl/olst_mem.sv */
// Single-port-write, single-port-read synchronous RAM holding the ids.
// Read data is registered. Depends on nothing.
module olst_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/olst_ctrl.sv */
// Sequencer of the ordered unique id list: scans, shifts and fetches
// through the id RAM and keeps the held count. Depends on olst_pkg.
module olst_ctrl #(
    parameter int DEPTH = olst_pkg::DEPTH_DEFAULT,
    parameter int IDW   = olst_pkg::ID_BITS_DEFAULT,
    parameter int AW    = 6,
    parameter int CW    = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_fire,
    input  olst_pkg::func_t     req_func,
    input  logic [IDW-1:0]      req_id,
    output logic                busy,
    input  logic                out_free,
    output olst_pkg::resp_ctl_t resp,
    output logic [IDW-1:0]      resp_id,
    output logic [CW-1:0]       count,
    output logic                mem_we,
    output logic [AW-1:0]       mem_waddr,
    output logic [IDW-1:0]      mem_wdata,
    output logic [AW-1:0]       mem_raddr,
    input  logic [IDW-1:0]      mem_rdata
);

    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    olst_pkg::state_t  state_reg, state_next;
    olst_pkg::func_t   func_reg, func_next;
    olst_pkg::status_t status_reg, status_next;
    logic [IDW-1:0]    id_reg, id_next;
    logic [IDW-1:0]    result_reg, result_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     scan_reg, scan_next;
    logic [CW-1:0]     pend_idx_reg, pend_idx_next;
    logic              pend_valid_reg, pend_valid_next;

    logic              issue;
    logic              hit;
    logic              miss;
    logic              shift_done;
    logic              last_after;
    logic [CW-1:0]     after_idx;
    logic [CW-1:0]     prev_idx;

    // Each cycle a read goes to scan_reg; its data is checked in the next cycle.
    assign issue      = (scan_reg < count_reg);
    assign hit        = pend_valid_reg && (mem_rdata == id_reg);
    assign miss       = !issue && !pend_valid_reg;
    assign shift_done = !issue && !pend_valid_reg;
    assign after_idx  = pend_idx_reg + 1'b1;
    assign prev_idx   = pend_idx_reg - 1'b1;
    assign last_after = (after_idx >= count_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            olst_pkg::S_IDLE:
            begin
                if (req_fire)
                begin
                    unique case (req_func)
                        olst_pkg::FN_INSERT,
                        olst_pkg::FN_REMOVE,
                        olst_pkg::FN_NEXT:  state_next = olst_pkg::S_SEARCH;
                        olst_pkg::FN_FIRST: state_next = (count_reg == '0) ?
                                                         olst_pkg::S_RESP :
                                                         olst_pkg::S_FETCH;
                        default:            state_next = olst_pkg::S_RESP;
                    endcase
                end
            end
            olst_pkg::S_SEARCH:
            begin
                if (hit)
                begin
                    unique case (func_reg)
                        olst_pkg::FN_REMOVE: state_next = olst_pkg::S_SHIFT;
                        olst_pkg::FN_NEXT:   state_next = last_after ?
                                                          olst_pkg::S_RESP :
                                                          olst_pkg::S_FETCH;
                        default:             state_next = olst_pkg::S_RESP;
                    endcase
                end
                else if (miss)
                begin
                    state_next = olst_pkg::S_RESP;
                end
            end
            olst_pkg::S_SHIFT:
            begin
                if (shift_done)
                begin
                    state_next = olst_pkg::S_RESP;
                end
            end
            olst_pkg::S_FETCH: state_next = olst_pkg::S_FDATA;
            olst_pkg::S_FDATA: state_next = olst_pkg::S_RESP;
            olst_pkg::S_RESP:
            begin
                if (out_free)
                begin
                    state_next = olst_pkg::S_IDLE;
                end
            end
            default: state_next = olst_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        func_next       = func_reg;
        id_next         = id_reg;
        status_next     = status_reg;
        result_next     = result_reg;
        count_next      = count_reg;
        scan_next       = scan_reg;
        pend_valid_next = 1'b0;
        pend_idx_next   = scan_reg;
        mem_we          = 1'b0;
        mem_waddr       = count_reg[AW-1:0];
        mem_wdata       = id_reg;
        mem_raddr       = scan_reg[AW-1:0];
        resp.done       = 1'b0;
        resp.status     = status_reg;
        unique case (state_reg)
            olst_pkg::S_IDLE:
            begin
                if (req_fire)
                begin
                    func_next   = req_func;
                    id_next     = req_id;
                    scan_next   = '0;
                    result_next = '0;
                    status_next = olst_pkg::ST_OK;
                    if ((req_func == olst_pkg::FN_FIRST) && (count_reg == '0))
                    begin
                        status_next = olst_pkg::ST_MISSING;
                    end
                end
            end
            olst_pkg::S_SEARCH:
            begin
                pend_valid_next = issue;
                if (issue)
                begin
                    scan_next = scan_reg + 1'b1;
                end
                if (hit)
                begin
                    pend_valid_next = 1'b0;
                    scan_next       = after_idx;
                    if (func_reg == olst_pkg::FN_INSERT)
                    begin
                        status_next = olst_pkg::ST_PRESENT;
                    end
                    else if ((func_reg == olst_pkg::FN_NEXT) && last_after)
                    begin
                        status_next = olst_pkg::ST_MISSING;
                    end
                end
                else if (miss)
                begin
                    if (func_reg == olst_pkg::FN_INSERT)
                    begin
                        if (count_reg == FULL_COUNT)
                        begin
                            status_next = olst_pkg::ST_FULL;
                        end
                        else
                        begin
                            // Append at the tail of the list.
                            mem_we     = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        status_next = olst_pkg::ST_MISSING;
                    end
                end
            end
            olst_pkg::S_SHIFT:
            begin
                // Entries behind the removed one move down by one slot.
                pend_valid_next = issue;
                if (issue)
                begin
                    scan_next = scan_reg + 1'b1;
                end
                if (pend_valid_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = prev_idx[AW-1:0];
                    mem_wdata = mem_rdata;
                end
                if (shift_done)
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            olst_pkg::S_FETCH:
            begin
            end
            olst_pkg::S_FDATA:
            begin
                result_next = mem_rdata;
            end
            olst_pkg::S_RESP:
            begin
                resp.done = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= olst_pkg::S_IDLE;
            count_reg      <= '0;
            scan_reg       <= '0;
            pend_valid_reg <= 1'b0;
            pend_idx_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            scan_reg       <= scan_next;
            pend_valid_reg <= pend_valid_next;
            pend_idx_reg   <= pend_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        id_reg     <= id_next;
        status_reg <= status_next;
        result_reg <= result_next;
    end

    assign busy    = (state_reg != olst_pkg::S_IDLE);
    assign resp_id = result_reg;
    assign count   = count_reg;

endmodule

/* hw/rtl/ordered_unique_id_list_core.sv */
// Insert, remove and next scan the held entries, one id RAM read per cycle; for a
// remove of a held id the scan and the shift together walk the held entries once.
// One request at a time: the next request is taken the cycle after the previous one
// has moved into the response register. Reset clears the held count and control
// state; the id RAM is not cleared.
module ordered_unique_id_list_core #(
    parameter int DEPTH   = olst_pkg::DEPTH_DEFAULT,
    parameter int ID_BITS = olst_pkg::ID_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_stall,
    input  logic [olst_pkg::FUNC_W-1:0]        func,
    input  logic [olst_pkg::ID_FIELD_W-1:0]    vertex_id,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output logic [olst_pkg::ID_FIELD_W-1:0]    result_id,
    output logic [olst_pkg::STATUS_W-1:0]      status,
    output logic [olst_pkg::COUNT_FIELD_W-1:0] entry_count
);

    localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int IFW = olst_pkg::ID_FIELD_W;
    localparam int NFW = olst_pkg::COUNT_FIELD_W;

    logic                busy;
    logic                req_fire;
    logic                out_free;
    logic [ID_BITS-1:0]  req_id;
    olst_pkg::resp_ctl_t resp;
    logic [ID_BITS-1:0]  resp_id;
    logic [IFW-1:0]      resp_id_field;
    logic [CW-1:0]       count;
    logic [NFW-1:0]      count_field;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [ID_BITS-1:0]  mem_wdata;
    logic [AW-1:0]       mem_raddr;
    logic [ID_BITS-1:0]  mem_rdata;

    logic                   rsp_valid_reg, rsp_valid_next;
    logic [IFW-1:0]         result_reg, result_next;
    olst_pkg::status_t      status_reg, status_next;
    logic [NFW-1:0]         count_out_reg, count_out_next;

    // A request is taken only while the sequencer is idle.
    assign req_stall = busy;
    assign req_fire  = req_valid && !busy;

    // The response register frees up when it is empty or being drained.
    assign out_free = !rsp_valid_reg || !rsp_stall;

    // The id field is taken at ID_BITS bits; results come back at the field width.
    generate
        if (ID_BITS >= IFW)
        begin : g_id_wide
            assign req_id        = ID_BITS'(vertex_id);
            assign resp_id_field = resp_id[IFW-1:0];
        end
        else
        begin : g_id_narrow
            assign req_id        = vertex_id[ID_BITS-1:0];
            assign resp_id_field = IFW'(resp_id);
        end
        if (CW >= NFW)
        begin : g_cnt_wide
            assign count_field = count[NFW-1:0];
        end
        else
        begin : g_cnt_narrow
            assign count_field = NFW'(count);
        end
    endgenerate

    olst_ctrl #(
        .DEPTH (DEPTH),
        .IDW   (ID_BITS),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_fire  (req_fire),
        .req_func  (olst_pkg::func_t'(func)),
        .req_id    (req_id),
        .busy      (busy),
        .out_free  (out_free),
        .resp      (resp),
        .resp_id   (resp_id),
        .count     (count),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    olst_mem #(
        .DEPTH (DEPTH),
        .WIDTH (ID_BITS),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Response register: loaded when the sequencer finishes and the slot is free.
    // The result id is forced to zero whenever the status is not ok.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        result_next    = result_reg;
        status_next    = status_reg;
        count_out_next = count_out_reg;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        if (resp.done && out_free)
        begin
            rsp_valid_next = 1'b1;
            status_next    = resp.status;
            count_out_next = count_field;
            result_next    = (resp.status == olst_pkg::ST_OK) ? resp_id_field : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg    <= result_next;
        status_reg    <= status_next;
        count_out_reg <= count_out_next;
    end

    assign rsp_valid   = rsp_valid_reg;
    assign result_id   = result_reg;
    assign status      = status_reg;
    assign entry_count = count_out_reg;

endmodule

/* hw/rtl/olst_chk.sv */
// Port-level checker for ordered_unique_id_list_core, with its bind statement.
// Depends on olst_pkg and ordered_unique_id_list_core.
module olst_props #(
    parameter int DEPTH = olst_pkg::DEPTH_DEFAULT
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               req_valid,
    input logic                               req_stall,
    input logic                               rsp_valid,
    input logic                               rsp_stall,
    input logic [olst_pkg::ID_FIELD_W-1:0]    result_id,
    input logic [olst_pkg::STATUS_W-1:0]      status,
    input logic [olst_pkg::COUNT_FIELD_W-1:0] entry_count
);

    localparam logic [olst_pkg::COUNT_FIELD_W-1:0] FULL_FIELD =
        olst_pkg::COUNT_FIELD_W'(DEPTH);

    // Only an ok response carries an id.
    a_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (status != olst_pkg::ST_OK)) |-> (result_id == '0))
        else $error("non-zero id on a failed response");

    // A full status is only reported with a full list.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (status == olst_pkg::ST_FULL)) |-> (entry_count == FULL_FIELD))
        else $error("full status with a list that is not full");

    // A request taken while idle makes the core busy in the next cycle.
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("core not busy after taking a request");

    // A stalled response holds.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=>
        (rsp_valid && $stable(result_id) && $stable(status) && $stable(entry_count)))
        else $error("stalled response changed");

endmodule

bind ordered_unique_id_list_core olst_props #(
    .DEPTH (DEPTH)
) u_olst_props (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .result_id   (result_id),
    .status      (status),
    .entry_count (entry_count)
);

/* verif/olst_chk.sv */
// Checker for the ordered unique id list: watches both channels, predicts each reply
// and compares it with what the core returns.
// Depends on olst_pkg for the field widths, the request codes and the status codes.
module olst_chk
    import olst_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    input  logic                     req_stall,
    input  logic [FUNC_W-1:0]        func,
    input  logic [ID_FIELD_W-1:0]    vertex_id,
    input  logic                     rsp_valid,
    input  logic                     rsp_stall,
    input  logic [ID_FIELD_W-1:0]    result_id,
    input  logic [STATUS_W-1:0]      status,
    input  logic [COUNT_FIELD_W-1:0] entry_count,
    output int                       mismatches,
    output int                       outstanding
);

    localparam int LIST_DEPTH   = DEPTH_DEFAULT;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [ID_FIELD_W-1:0]    id;
        status_t                  st;
        logic [COUNT_FIELD_W-1:0] count;
    } list_reply_t;

    // Our own copy of the list, oldest id first, and the replies still owed.
    logic [ID_FIELD_W-1:0] held_ids[$];
    list_reply_t           replies_due[$];
    int                    bad_count;

    function automatic int locate_id(logic [ID_FIELD_W-1:0] id);
        for (int i = 0; i < held_ids.size(); i++)
        begin
            if (held_ids[i] == id)
                return i;
        end
        return -1;
    endfunction

    // Applies one request to the list copy and returns the reply it should produce.
    function automatic list_reply_t apply_request(logic [FUNC_W-1:0] f,
                                                  logic [ID_FIELD_W-1:0] raw_id);
        list_reply_t           r;
        logic [ID_FIELD_W-1:0] key;
        int                    slot;
        key   = raw_id & ID_FIELD_W'((64'd1 << ID_BITS_DEFAULT) - 1);
        r.id  = '0;
        r.st  = ST_OK;
        slot  = locate_id(key);
        case (f)
            FN_INSERT:
            begin
                // The presence check wins over the full check.
                if (slot >= 0)
                    r.st = ST_PRESENT;
                else if (held_ids.size() >= LIST_DEPTH)
                    r.st = ST_FULL;
                else
                    held_ids.push_back(key);
            end
            FN_REMOVE:
            begin
                if (slot < 0)
                    r.st = ST_MISSING;
                else
                    held_ids.delete(slot);
            end
            FN_FIRST:
            begin
                if (held_ids.size() == 0)
                    r.st = ST_MISSING;
                else
                    r.id = held_ids[0];
            end
            FN_NEXT:
            begin
                if (slot < 0 || slot + 1 >= held_ids.size())
                    r.st = ST_MISSING;
                else
                    r.id = held_ids[slot + 1];
            end
            default:
            begin
            end
        endcase
        r.count = COUNT_FIELD_W'(held_ids.size());
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        list_reply_t want;
        if (!rst_n)
        begin
            held_ids.delete();
            replies_due.delete();
            bad_count = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            // Replies are retired before the new request is queued, so a reply and a
            // request in the same cycle never confuse the ordering.
            if (rsp_valid && !rsp_stall)
            begin
                if (replies_due.size() == 0)
                begin
                    bad_count++;
                    if (bad_count <= REPORT_LIMIT)
                        $display("olst_chk: unexpected reply id=%0h status=%0d count=%0d",
                                 result_id, status, entry_count);
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (result_id !== want.id || status !== want.st
                        || entry_count !== want.count)
                    begin
                        bad_count++;
                        if (bad_count <= REPORT_LIMIT)
                        begin
                            $write("olst_chk: reply mismatch, expected id=%0h status=%0d",
                                   want.id, want.st);
                            $display(" count=%0d, got id=%0h status=%0d count=%0d",
                                     want.count, result_id, status, entry_count);
                        end
                    end
                end
            end
            if (req_valid && !req_stall)
                replies_due.push_back(apply_request(func, vertex_id));
            mismatches  <= bad_count;
            outstanding <= replies_due.size();
        end
    end

endmodule

/* verif/tb.sv */
// Top of the ordered unique id list testbench: drives requests into the core, paces
// the reply side and gives the verdict.
// Depends on olst_pkg, ordered_unique_id_list_core and the olst_chk checker.
module tb;
    import olst_pkg::*;

    // The list holds at most DEPTH_DEFAULT ids; most ids come from a small pool so
    // that inserts collide, removes hit and successor queries find their id.
    localparam int POOL_SIZE     = 96;
    localparam int RANDOM_ITEMS  = 1850;
    localparam int FUNC_CODE_MAX = 7;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 200;
    localparam int CYCLE_LIMIT   = 1500000;
    localparam int LIST_DEPTH    = DEPTH_DEFAULT;

    typedef enum int {
        EP_FILL,
        EP_GROW,
        EP_SHRINK,
        EP_MIXED,
        EP_NOISE
    } episode_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     req_valid = 1'b0;
    logic                     req_stall;
    logic [FUNC_W-1:0]        func = FN_SIZE;
    logic [ID_FIELD_W-1:0]    vertex_id = '0;
    logic                     rsp_valid;
    logic                     rsp_stall = 1'b0;
    logic [ID_FIELD_W-1:0]    result_id;
    logic [STATUS_W-1:0]      status;
    logic [COUNT_FIELD_W-1:0] entry_count;

    int mismatches;
    int outstanding;
    int cycle_count = 0;

    // Pacing controls shared by the request and reply processes. A quiet side never
    // idles, which gives back-to-back stretches; the hold request asks the reply side
    // for one long stall so that the core backs up into its request port.
    bit tx_quiet = 1'b1;
    bit rx_quiet = 1'b1;
    bit rx_hold_req = 1'b0;

    logic [ID_FIELD_W-1:0] id_pool [POOL_SIZE];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    ordered_unique_id_list_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .func        (func),
        .vertex_id   (vertex_id),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .result_id   (result_id),
        .status      (status),
        .entry_count (entry_count)
    );

    olst_chk checker_inst (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .func        (func),
        .vertex_id   (vertex_id),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .result_id   (result_id),
        .status      (status),
        .entry_count (entry_count),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Watchdog: reaching CYCLE_LIMIT means the core has hung or dropped a reply.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Offers one request, after a random idle gap unless the sender is quiet, and
    // returns at the edge where the core takes it. The payload holds while stalled.
    task automatic send_request(input logic [FUNC_W-1:0] f,
                                input logic [ID_FIELD_W-1:0] id);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        func      <= f;
        vertex_id <= id;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    // Mostly pool ids; now and then any 16-bit value, which keeps every bit moving
    // and produces plenty of absent ids.
    function automatic logic [ID_FIELD_W-1:0] pick_id();
        if ($urandom_range(0, 9) == 0)
            return ID_FIELD_W'($urandom_range(0, 65535));
        return id_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    // Chooses a request code with a mix that depends on the kind of episode: growing
    // episodes lean on inserts, shrinking ones on removes. Unused codes show up too.
    function automatic logic [FUNC_W-1:0] pick_func(episode_t ep);
        int roll;
        int lim_ins;
        int lim_rem;
        int lim_first;
        int lim_next;
        roll = $urandom_range(0, 99);
        case (ep)
            EP_GROW:
            begin
                lim_ins = 60; lim_rem = 70; lim_first = 75; lim_next = 90;
            end
            EP_SHRINK:
            begin
                lim_ins = 15; lim_rem = 65; lim_first = 70; lim_next = 85;
            end
            EP_MIXED:
            begin
                lim_ins = 30; lim_rem = 55; lim_first = 65; lim_next = 85;
            end
            default:
                return FUNC_W'($urandom_range(0, FUNC_CODE_MAX));
        endcase
        if (roll < lim_ins)
            return FN_INSERT;
        if (roll < lim_rem)
            return FN_REMOVE;
        if (roll < lim_first)
            return FN_FIRST;
        if (roll < lim_next)
            return FN_NEXT;
        if (roll < 95)
            return FN_SIZE;
        return FUNC_W'($urandom_range(FN_SIZE + 1, FUNC_CODE_MAX));
    endfunction

    // Reply side: stalls for a random number of cycles before each reply, or not at
    // all while quiet, and once holds off for a long stretch on request.
    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            gap = rx_quiet ? 0 : $urandom_range(0, 19);
            if (gap > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            do
                @(posedge clk);
            while (!rsp_valid || rsp_stall);
        end
    end

    // Request side and verdict.
    initial
    begin
        episode_t ep;
        int       random_sent;
        int       run_len;
        int       base;
        bit       hold_done;
        bit       drain_done;

        for (int i = 0; i < POOL_SIZE; i++)
            id_pool[i] = ID_FIELD_W'($urandom_range(0, 65535));
        // The extremes of the id field are always in the pool.
        id_pool[0] = '0;
        id_pool[1] = '1;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: every query on an empty list, inserts of both extreme ids and
        // a duplicate, successor of the head, of the last and of an absent id,
        // removal from the middle, from the head and of an absent id, the unused
        // request codes, and draining back to empty.
        send_request(FN_FIRST, 16'h0000);
        send_request(FN_NEXT, 16'h0000);
        send_request(FN_REMOVE, 16'h0000);
        send_request(FN_INSERT, 16'h0000);
        send_request(FN_INSERT, 16'hFFFF);
        send_request(FN_INSERT, 16'h0000);
        send_request(FN_INSERT, 16'h5A5A);
        send_request(FN_FIRST, 16'hFFFF);
        send_request(FN_NEXT, 16'h0000);
        send_request(FN_NEXT, 16'h5A5A);
        send_request(FN_NEXT, 16'h1234);
        send_request(FN_REMOVE, 16'hFFFF);
        send_request(FN_NEXT, 16'h0000);
        send_request(FN_REMOVE, 16'h1234);
        send_request(FN_SIZE, 16'hA5A5);
        send_request(FUNC_W'(FN_SIZE + 1), 16'h0000);
        send_request(FUNC_W'(FN_SIZE + 2), 16'hFFFF);
        send_request(FUNC_W'(FUNC_CODE_MAX), 16'h5A5A);
        send_request(FN_REMOVE, 16'h0000);
        send_request(FN_FIRST, 16'h0000);
        send_request(FN_REMOVE, 16'h5A5A);
        send_request(FN_SIZE, 16'h0000);

        // Random part, built from episodes. The first is always a fill so the list
        // reaches its bound early; later ones are picked at random.
        random_sent = 0;
        hold_done   = 1'b0;
        drain_done  = 1'b0;
        ep          = EP_FILL;
        while (random_sent < RANDOM_ITEMS)
        begin
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);

            // Once, a long stall on the reply side while requests keep coming.
            if (!hold_done && random_sent >= 400)
            begin
                hold_done   = 1'b1;
                rx_hold_req = 1'b1;
            end

            // Once, stop sending until every owed reply has come back.
            if (!drain_done && random_sent >= 1000)
            begin
                drain_done = 1'b1;
                req_valid <= 1'b0;
                do
                    @(posedge clk);
                while (outstanding != 0);
            end

            if (ep == EP_FILL)
            begin
                // Insert a run of distinct pool ids past the bound, retry a few held
                // ids (duplicate while full), then walk the list head to tail.
                base = $urandom_range(0, POOL_SIZE - 1);
                for (int k = 0; k < LIST_DEPTH + 6; k++)
                    send_request(FN_INSERT, id_pool[(base + k) % POOL_SIZE]);
                for (int k = 0; k < 4; k++)
                    send_request(FN_INSERT,
                                 id_pool[(base + $urandom_range(0, 3)) % POOL_SIZE]);
                send_request(FN_FIRST, pick_id());
                for (int k = 0; k < LIST_DEPTH + 2; k++)
                    send_request(FN_NEXT, id_pool[(base + k) % POOL_SIZE]);
                random_sent += 2 * LIST_DEPTH + 13;
            end
            else
            begin
                run_len = (ep == EP_NOISE) ? $urandom_range(10, 30) : $urandom_range(20, 80);
                for (int k = 0; k < run_len; k++)
                begin
                    if (ep == EP_NOISE)
                        send_request(pick_func(ep), ID_FIELD_W'($urandom_range(0, 65535)));
                    else
                        send_request(pick_func(ep), pick_id());
                end
                random_sent += run_len;
            end

            case ($urandom_range(0, 19))
                0, 1, 2:    ep = EP_FILL;
                3, 4, 5, 6, 7: ep = EP_GROW;
                8, 9, 10, 11, 12: ep = EP_SHRINK;
                13, 14, 15, 16, 17: ep = EP_MIXED;
                default:    ep = EP_NOISE;
            endcase
        end

        // Wind down: no more requests, wait for every owed reply, then give the core
        // time to show any reply it should not produce.
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
